// ===== hdl/dprh_pkg.sv =====
package dprh_pkg;

   localparam int MAX_LEN = 4096;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 9;
   localparam int HASH_W  = 30;
   localparam int OUT_W   = 62;
   localparam int PROD_W  = 2 * HASH_W;
   localparam int QUO_W   = HASH_W + 1;
   localparam int MU_W    = HASH_W + 1;
   localparam int RED_W   = HASH_W + 2;
   localparam int MUL_LAT = 4;

   localparam logic [HASH_W-1:0] HASH_BASE  = 30'd131;
   localparam logic [HASH_W-1:0] MOD_FIRST  = 30'd1000000021;
   localparam logic [HASH_W-1:0] MOD_SECOND = 30'd1000000009;

   // barrett constants floor(2^60 / m)
   localparam logic [63:0] TWO_POW_PROD = 64'd1 << PROD_W;
   localparam logic [MU_W-1:0] MU_FIRST  = MU_W'(TWO_POW_PROD / 64'(MOD_FIRST));
   localparam logic [MU_W-1:0] MU_SECOND = MU_W'(TWO_POW_PROD / 64'(MOD_SECOND));

   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      SRC_HASH  = 2'd0,
      SRC_POWER = 2'd1,
      SRC_QUERY = 2'd2
   } mul_src_type;

   typedef struct packed {
      logic        accept;
      logic        mul_go;
      mul_src_type mul_src;
      logic        rd_lo;
      logic        rd_hi;
      logic        commit;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic query;
      logic mul_last_done;
   } sts_type;

   function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                 input logic [SYM_W-1:0] s,
                                                 input logic [HASH_W-1:0] m);
      logic [HASH_W:0] sum;
      sum = {1'b0, a} + (HASH_W + 1)'(s);
      if (sum >= {1'b0, m}) begin
         add_mod = HASH_W'(sum - {1'b0, m});
      end else begin
         add_mod = sum[HASH_W-1:0];
      end
   endfunction

   function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b,
                                                 input logic [HASH_W-1:0] m);
      if (a >= b) begin
         sub_mod = a - b;
      end else begin
         sub_mod = HASH_W'({1'b0, a} + {1'b0, m} - {1'b0, b});
      end
   endfunction

endpackage

// ===== hdl/dprh_if.sv =====
interface dprh_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic                       restart;
   logic [dprh_pkg::SYM_W-1:0] symbol;
   logic [dprh_pkg::IDX_W-1:0] first_index;
   logic [dprh_pkg::IDX_W-1:0] last_index;

   modport source (output valid, output req_type, output restart, output symbol,
                   output first_index, output last_index, input ready);
   modport sink (input valid, input req_type, input restart, input symbol,
                 input first_index, input last_index, output ready);
endinterface

interface dprh_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dprh_pkg::OUT_W-1:0] hash_value;
   logic [1:0]                 status;
   logic [dprh_pkg::LEN_W-1:0] string_length;

   modport source (output valid, output hash_value, output status, output string_length,
                   input ready);
   modport sink (input valid, input hash_value, input status, input string_length,
                 output ready);
endinterface

// ===== hdl/dprh_ram.sv =====
module dprh_ram #(
   parameter int Width = 60,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dprh_modmul.sv =====
module dprh_modmul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic                        tag,
   input  logic [dprh_pkg::HASH_W-1:0] a,
   input  logic [dprh_pkg::HASH_W-1:0] b,
   input  logic [dprh_pkg::HASH_W-1:0] m,
   input  logic [dprh_pkg::MU_W-1:0]   mu,
   output logic                        done,
   output logic                        done_tag,
   output logic [dprh_pkg::HASH_W-1:0] result
);
   import dprh_pkg::*;

   logic [MUL_LAT-1:0]        vld_ff, vld_in;
   logic [MUL_LAT-1:0]        tag_ff, tag_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [2*QUO_W-1:0]        q2_ff, q2_in;
   logic [RED_W-1:0]          lo1_ff, lo2_ff;
   logic [QUO_W+HASH_W-1:0]   q3m_full;
   logic [RED_W-1:0]          q3m_ff, q3m_in;
   logic [RED_W-1:0]          r_ff, r_in;
   logic [RED_W-1:0]          m1, m2;

   // barrett: q1 = x >> 29, q3 = (q1 * mu) >> 31, r = x - q3 * m < 3m
   assign prod_in  = a * b;
   assign q2_in    = prod_ff[PROD_W-1:HASH_W-1] * mu;
   assign q3m_full = q2_ff[2*QUO_W-1:QUO_W] * m;
   assign q3m_in   = q3m_full[RED_W-1:0];
   assign r_in     = lo2_ff - q3m_ff;
   assign vld_in   = {vld_ff[MUL_LAT-2:0], go};
   assign tag_in   = {tag_ff[MUL_LAT-2:0], tag};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      tag_ff  <= tag_in;
      prod_ff <= prod_in;
      q2_ff   <= q2_in;
      lo1_ff  <= prod_ff[RED_W-1:0];
      q3m_ff  <= q3m_in;
      lo2_ff  <= lo1_ff;
      r_ff    <= r_in;
   end

   assign m1 = RED_W'(m);
   assign m2 = RED_W'({m, 1'b0});

   always_comb begin
      if (r_ff >= m2) begin
         result = HASH_W'(r_ff - m2);
      end else if (r_ff >= m1) begin
         result = HASH_W'(r_ff - m1);
      end else begin
         result = r_ff[HASH_W-1:0];
      end
   end

   assign done     = vld_ff[MUL_LAT-1];
   assign done_tag = tag_ff[MUL_LAT-1];

   a_done_follows_go: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(go, MUL_LAT))
      else $error("modmul result without a matching issue");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done |-> (result < m))
      else $error("modmul result not reduced below modulus");

endmodule

// ===== hdl/dprh_datapath.sv =====
module dprh_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_type,
   input  logic                        restart,
   input  logic [dprh_pkg::SYM_W-1:0]  symbol,
   input  logic [dprh_pkg::IDX_W-1:0]  first_index,
   input  logic [dprh_pkg::IDX_W-1:0]  last_index,
   input  dprh_pkg::cmd_type           cmd,
   output dprh_pkg::sts_type           sts,
   output logic [dprh_pkg::OUT_W-1:0]  hash_value,
   output logic [1:0]                  status,
   output logic [dprh_pkg::LEN_W-1:0]  string_length
);
   import dprh_pkg::*;

   logic                query_ff;
   logic [SYM_W-1:0]    sym_ff;
   logic [IDX_W-1:0]    lo_ff, hi_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [HASH_W-1:0]   hf_last_ff, hf_last_in, hs_last_ff, hs_last_in;
   logic [HASH_W-1:0]   pwf_ff, pwf_in, pws_ff, pws_in;
   logic [HASH_W-1:0]   mhf_ff, mhs_ff, mpf_ff, mps_ff;
   logic [HASH_W-1:0]   resf_ff, resf_in, ress_ff, ress_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [OUT_W-1:0]    rsp_hash_ff;
   logic [1:0]          rsp_status_ff;
   logic [LEN_W-1:0]    rsp_len_ff;

   logic                bad_range, store_full;
   logic [HASH_W-1:0]   opf_a, opf_b, ops_a, ops_b;
   logic                mul_tag;
   logic                done_f, done_s, tag_f, tag_s;
   logic [HASH_W-1:0]   mm_f, mm_s;
   logic [2*HASH_W-1:0] pre_rd, pow_rd, pre_wr, pow_wr;
   logic                pre_rd_en, app_wr;
   logic [IDX_W-1:0]    pre_rd_addr, pow_rd_addr;
   logic [HASH_W-1:0]   pre_hi_f, pre_hi_s, app_f, app_s, qry_f, qry_s;

   // request decode
   assign bad_range  = (first_index > last_index) || (LEN_W'(last_index) >= len_ff);
   assign store_full = !restart && (len_ff == LEN_W'(MAX_LEN));
   assign sts.query  = (req_type == REQ_QUERY);
   assign sts.quick  = (req_type == REQ_QUERY) ? bad_range : store_full;
   assign sts.mul_last_done = done_f && tag_f;

   // multiplier operands
   assign mul_tag = (cmd.mul_src != SRC_HASH);

   always_comb begin
      case (cmd.mul_src)
         SRC_HASH: begin
            opf_a = hf_last_ff;
            ops_a = hs_last_ff;
            opf_b = HASH_BASE;
            ops_b = HASH_BASE;
         end
         SRC_POWER: begin
            opf_a = pwf_ff;
            ops_a = pws_ff;
            opf_b = HASH_BASE;
            ops_b = HASH_BASE;
         end
         SRC_QUERY: begin
            // a span from position zero has no prefix to remove
            opf_a = (lo_ff == '0) ? '0 : pre_rd[2*HASH_W-1:HASH_W];
            ops_a = (lo_ff == '0) ? '0 : pre_rd[HASH_W-1:0];
            opf_b = pow_rd[2*HASH_W-1:HASH_W];
            ops_b = pow_rd[HASH_W-1:0];
         end
         default: begin
            opf_a = '0;
            ops_a = '0;
            opf_b = '0;
            ops_b = '0;
         end
      endcase
   end

   dprh_modmul u_mm_first (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.mul_go),
      .tag      (mul_tag),
      .a        (opf_a),
      .b        (opf_b),
      .m        (MOD_FIRST),
      .mu       (MU_FIRST),
      .done     (done_f),
      .done_tag (tag_f),
      .result   (mm_f)
   );

   dprh_modmul u_mm_second (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.mul_go),
      .tag      (mul_tag),
      .a        (ops_a),
      .b        (ops_b),
      .m        (MOD_SECOND),
      .mu       (MU_SECOND),
      .done     (done_s),
      .done_tag (tag_s),
      .result   (mm_s)
   );

   // prefix hashes, power of 131 for length k stored at k - 1
   assign pre_rd_en   = cmd.rd_lo || cmd.rd_hi;
   assign pre_rd_addr = cmd.rd_hi ? hi_ff : IDX_W'(lo_ff - 1'b1);
   assign pow_rd_addr = IDX_W'(hi_ff - lo_ff);
   assign app_wr      = cmd.commit && !query_ff;
   assign pre_wr      = {app_f, app_s};
   assign pow_wr      = {mpf_ff, mps_ff};

   dprh_ram #(.Width(2 * HASH_W), .Depth(MAX_LEN)) u_prefix_ram (
      .clock   (clock),
      .wr_en   (app_wr),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (pre_wr),
      .rd_en   (pre_rd_en),
      .rd_addr (pre_rd_addr),
      .rd_data (pre_rd)
   );

   dprh_ram #(.Width(2 * HASH_W), .Depth(MAX_LEN)) u_power_ram (
      .clock   (clock),
      .wr_en   (app_wr),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (pow_wr),
      .rd_en   (cmd.rd_lo),
      .rd_addr (pow_rd_addr),
      .rd_data (pow_rd)
   );

   // final modular add or subtract
   assign pre_hi_f = pre_rd[2*HASH_W-1:HASH_W];
   assign pre_hi_s = pre_rd[HASH_W-1:0];
   assign app_f = (len_ff == '0) ? HASH_W'(sym_ff) : add_mod(mhf_ff, sym_ff, MOD_FIRST);
   assign app_s = (len_ff == '0) ? HASH_W'(sym_ff) : add_mod(mhs_ff, sym_ff, MOD_SECOND);
   assign qry_f = (lo_ff == '0) ? pre_hi_f : sub_mod(pre_hi_f, mpf_ff, MOD_FIRST);
   assign qry_s = (lo_ff == '0) ? pre_hi_s : sub_mod(pre_hi_s, mps_ff, MOD_SECOND);

   always_comb begin
      len_in        = len_ff;
      hf_last_in    = hf_last_ff;
      hs_last_in    = hs_last_ff;
      pwf_in        = pwf_ff;
      pws_in        = pws_ff;
      resf_in       = resf_ff;
      ress_in       = ress_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         if (req_type == REQ_APPEND && restart) begin
            len_in = '0;
            pwf_in = HASH_W'(1);
            pws_in = HASH_W'(1);
         end
         if (req_type == REQ_QUERY) begin
            resf_in       = '0;
            ress_in       = '0;
            res_status_in = STATUS_BAD_RANGE;
         end else begin
            resf_in       = hf_last_ff;
            ress_in       = hs_last_ff;
            res_status_in = STATUS_FULL;
         end
      end
      if (cmd.commit) begin
         res_status_in = STATUS_OK;
         if (query_ff) begin
            resf_in = qry_f;
            ress_in = qry_s;
         end else begin
            resf_in    = app_f;
            ress_in    = app_s;
            hf_last_in = app_f;
            hs_last_in = app_s;
            pwf_in     = mpf_ff;
            pws_in     = mps_ff;
            len_in     = LEN_W'(len_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         pwf_ff     <= HASH_W'(1);
         pws_ff     <= HASH_W'(1);
         hf_last_ff <= '0;
         hs_last_ff <= '0;
      end else begin
         len_ff     <= len_in;
         pwf_ff     <= pwf_in;
         pws_ff     <= pws_in;
         hf_last_ff <= hf_last_in;
         hs_last_ff <= hs_last_in;
      end
      resf_ff       <= resf_in;
      ress_ff       <= ress_in;
      res_status_ff <= res_status_in;
      if (cmd.accept) begin
         query_ff <= (req_type == REQ_QUERY);
         sym_ff   <= symbol;
         lo_ff    <= first_index;
         hi_ff    <= last_index;
      end
      if (done_f) begin
         if (tag_f) begin
            mpf_ff <= mm_f;
         end else begin
            mhf_ff <= mm_f;
         end
      end
      if (done_s) begin
         if (tag_s) begin
            mps_ff <= mm_s;
         end else begin
            mhs_ff <= mm_s;
         end
      end
      if (cmd.load_rsp) begin
         rsp_hash_ff   <= {resf_ff, {(OUT_W - 2 * HASH_W){1'b0}}, ress_ff};
         rsp_status_ff <= res_status_ff;
         rsp_len_ff    <= len_ff;
      end
   end

   assign hash_value    = rsp_hash_ff;
   assign status        = rsp_status_ff;
   assign string_length = rsp_len_ff;

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("stored length above capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !query_ff) |=> (len_ff == $past(len_ff) + 1'b1))
      else $error("append did not grow the string by one");

endmodule

// ===== hdl/dprh_ctrl.sv =====
module dprh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dprh_pkg::sts_type sts,
   output dprh_pkg::cmd_type cmd
);
   import dprh_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_APP_H   = 8'b0000_0010,
      ST_APP_P   = 8'b0000_0100,
      ST_QRY_RD  = 8'b0000_1000,
      ST_QRY_MUL = 8'b0001_0000,
      ST_WAIT    = 8'b0010_0000,
      ST_FINISH  = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.accept    = 1'b0;
      cmd.mul_go    = 1'b0;
      cmd.mul_src   = SRC_HASH;
      cmd.rd_lo     = 1'b0;
      cmd.rd_hi     = 1'b0;
      cmd.commit    = 1'b0;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.quick) begin
                  state_in = ST_DONE;
               end else if (sts.query) begin
                  state_in = ST_QRY_RD;
               end else begin
                  state_in = ST_APP_H;
               end
            end
         end
         ST_APP_H: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_src = SRC_HASH;
            state_in    = ST_APP_P;
         end
         ST_APP_P: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_src = SRC_POWER;
            state_in    = ST_WAIT;
         end
         ST_QRY_RD: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_QRY_MUL;
         end
         ST_QRY_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_src = SRC_QUERY;
            cmd.rd_hi   = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.mul_last_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/double_prefix_rolling_hash_top.sv =====
// channel   dir  handshake     contents
// req_chan  in   valid/ready   req_type, restart, symbol, first_index, last_index
// rsp_chan  out  valid/ready   hash_value, status, string_length
//
// append or in-range query: accept, the issue states (hash then power multiply, or
// ram read then multiply), the four-stage barrett multiplier, one per modulus,
// final add or subtract, load; bad range or full store: accept, load, no multiply
// reset clears length, power and last hash registers; hash stores hold no reset value
// a waiting response lets one more request in, which then holds before its load
module double_prefix_rolling_hash_top (
   input logic       clock,
   input logic       reset,
   dprh_req_if.sink  req_chan,
   dprh_rsp_if.source rsp_chan
);
   import dprh_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dprh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dprh_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_chan.req_type),
      .restart       (req_chan.restart),
      .symbol        (req_chan.symbol),
      .first_index   (req_chan.first_index),
      .last_index    (req_chan.last_index),
      .cmd           (cmd),
      .sts           (sts),
      .hash_value    (rsp_chan.hash_value),
      .status        (rsp_chan.status),
      .string_length (rsp_chan.string_length)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import dprh_pkg::*;

   localparam int              WATCHDOG_LIMIT = 4000;
   localparam int              HOLD_CYCLES    = 300;
   localparam int              RANDOM_ITEMS   = 1150;
   localparam longint unsigned MOD_A          = 64'(MOD_FIRST);
   localparam longint unsigned MOD_B          = 64'(MOD_SECOND);
   localparam longint unsigned BASE           = 64'(HASH_BASE);

   typedef struct packed {
      logic [OUT_W-1:0] hash_value;
      logic [1:0]       status;
      logic [LEN_W-1:0] string_length;
   } hash_result_type;

   logic clock = 1'b0;
   logic reset;

   dprh_req_if req_chan ();
   dprh_rsp_if rsp_chan ();

   double_prefix_rolling_hash_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   longint unsigned model_pre_first [MAX_LEN];
   longint unsigned model_pre_second[MAX_LEN];
   longint unsigned model_pow_first [MAX_LEN+1];
   longint unsigned model_pow_second[MAX_LEN+1];
   int unsigned     model_len;

   hash_result_type pending_hash_results[$];
   int              mismatch_count = 0;
   int              requests_sent  = 0;
   bit              req_idle_on    = 1'b1;
   logic            rsp_idle_on    = 1'b1;
   int              stall_asked    = 0;
   int              stall_taken    = 0;
   int              hold_left      = 0;
   int              quiet_cycles   = 0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic logic [OUT_W-1:0] pack_hashes(input longint unsigned a,
                                                    input longint unsigned b);
      return OUT_W'((a << 32) | b);
   endfunction

   function automatic longint unsigned span_hash(input bit use_second, input int unsigned lo,
                                                 input int unsigned hi);
      longint unsigned m;
      longint unsigned whole;
      longint unsigned cut;
      m     = use_second ? MOD_B : MOD_A;
      whole = use_second ? model_pre_second[hi] : model_pre_first[hi];
      if (lo == 0) begin
         return whole;
      end
      if (use_second) begin
         cut = (model_pre_second[lo-1] * model_pow_second[hi-lo+1]) % m;
      end else begin
         cut = (model_pre_first[lo-1] * model_pow_first[hi-lo+1]) % m;
      end
      return (whole + m - cut) % m;
   endfunction

   function automatic hash_result_type predict_hash_result(input logic kind, input logic fresh,
                                                           input logic [SYM_W-1:0] sym,
                                                           input logic [IDX_W-1:0] lo,
                                                           input logic [IDX_W-1:0] hi);
      hash_result_type r;
      int unsigned     p;
      r = '0;
      if (kind == REQ_APPEND) begin
         if (fresh) begin
            model_len = 0;
         end
         if (model_len >= MAX_LEN) begin
            r.status     = STATUS_FULL;
            r.hash_value = pack_hashes(model_pre_first[MAX_LEN-1], model_pre_second[MAX_LEN-1]);
         end else begin
            p = model_len;
            if (p == 0) begin
               model_pre_first[0]  = 64'(sym);
               model_pre_second[0] = 64'(sym);
            end else begin
               model_pre_first[p]  = ((model_pre_first[p-1] * BASE) % MOD_A + 64'(sym)) % MOD_A;
               model_pre_second[p] = ((model_pre_second[p-1] * BASE) % MOD_B + 64'(sym)) % MOD_B;
            end
            model_pow_first[p+1]  = (model_pow_first[p] * BASE) % MOD_A;
            model_pow_second[p+1] = (model_pow_second[p] * BASE) % MOD_B;
            model_len             = p + 1;
            r.status              = STATUS_OK;
            r.hash_value          = pack_hashes(model_pre_first[p], model_pre_second[p]);
         end
      end else if (lo > hi || hi >= model_len) begin
         r.status = STATUS_BAD_RANGE;
      end else begin
         r.status     = STATUS_OK;
         r.hash_value = pack_hashes(span_hash(1'b0, lo, hi), span_hash(1'b1, lo, hi));
      end
      r.string_length = LEN_W'(model_len);
      return r;
   endfunction

   // returns at the edge where the request is taken
   task automatic send_request(input logic kind, input logic fresh, input logic [SYM_W-1:0] sym,
                               input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
      if (req_idle_on && $urandom_range(0, 99) < 27) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 27);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.restart     <= fresh;
      req_chan.symbol      <= sym;
      req_chan.first_index <= lo;
      req_chan.last_index  <= hi;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      pending_hash_results.insert(pending_hash_results.size(),
                                  predict_hash_result(kind, fresh, sym, lo, hi));
      requests_sent++;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol();
      if ($urandom_range(0, 9) == 0) begin
         return SYM_W'($urandom_range(0, 511));
      end
      return SYM_W'($urandom_range(1, 256));
   endfunction

   task automatic append_symbol(input logic fresh, input logic [SYM_W-1:0] sym);
      send_request(REQ_APPEND, fresh, sym, IDX_W'($urandom_range(0, MAX_LEN-1)),
                   IDX_W'($urandom_range(0, MAX_LEN-1)));
   endtask

   task automatic query_span(input int unsigned lo, input int unsigned hi);
      send_request(REQ_QUERY, 1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 511)),
                   IDX_W'(lo), IDX_W'(hi));
   endtask

   task automatic query_random_span();
      int unsigned lo;
      int unsigned hi;
      if (model_len != 0 && $urandom_range(0, 99) < 85) begin
         lo = $urandom_range(0, model_len - 1);
         hi = $urandom_range(lo, model_len - 1);
      end else begin
         lo = $urandom_range(0, MAX_LEN - 1);
         hi = $urandom_range(0, MAX_LEN - 1);
      end
      query_span(lo, hi);
   endtask

   task automatic test_directed();
      query_span(0, 0);
      query_span(MAX_LEN-1, MAX_LEN-1);
      append_symbol(1'b1, 9'd1);
      append_symbol(1'b0, 9'd256);
      append_symbol(1'b0, 9'd0);
      append_symbol(1'b0, 9'd511);
      append_symbol(1'b0, 9'd131);
      query_span(0, 4);
      query_span(0, 0);
      query_span(1, 3);
      query_span(4, 4);
      query_span(2, 1);
      query_span(0, 5);
      query_span(MAX_LEN-1, 0);
      query_span(0, MAX_LEN-1);
      send_request(REQ_QUERY, 1'b1, 9'd5, IDX_W'(1), IDX_W'(2));
      append_symbol(1'b1, 9'd77);
      query_span(0, 0);
      query_span(0, 1);
      append_symbol(1'b0, 9'd200);
      query_span(1, 1);
   endtask

   task automatic test_store_full();
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      append_symbol(1'b1, pick_symbol());
      repeat (MAX_LEN - 1) append_symbol(1'b0, pick_symbol());
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      append_symbol(1'b0, 9'd0);
      append_symbol(1'b0, 9'd511);
      append_symbol(1'b0, pick_symbol());
      query_span(0, MAX_LEN-1);
      query_span(MAX_LEN-1, MAX_LEN-1);
      query_span(1, MAX_LEN-1);
      query_span(MAX_LEN/2, MAX_LEN-1);
      query_span(MAX_LEN-1, MAX_LEN-2);
      repeat (10) query_random_span();
      append_symbol(1'b1, pick_symbol());
      query_span(0, 0);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      stall_asked++;
      repeat (12) begin
         if ($urandom_range(0, 1) == 0) begin
            append_symbol(1'b0, pick_symbol());
         end else begin
            query_random_span();
         end
      end
   endtask

   task automatic test_random();
      int          stop_at;
      int unsigned run;
      stop_at = requests_sent + RANDOM_ITEMS;
      while (requests_sent < stop_at) begin
         case ($urandom_range(0, 99)) inside
            [0:69]: begin
               append_symbol(1'b1, pick_symbol());
               run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
               repeat (run) begin
                  if ($urandom_range(0, 99) < 60) begin
                     append_symbol(1'b0, pick_symbol());
                  end else begin
                     query_random_span();
                  end
               end
            end
            [70:84]: begin
               repeat ($urandom_range(1, 8)) query_random_span();
            end
            default: begin
               send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0),
                            SYM_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, MAX_LEN-1)),
                            IDX_W'($urandom_range(0, MAX_LEN-1)));
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (stall_asked != stall_taken) begin
         stall_taken = stall_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_idle_on) begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= 27);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      hash_result_type want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_hash_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: hash %h status %0d len %0d",
                                      rsp_chan.hash_value, rsp_chan.status,
                                      rsp_chan.string_length));
         end else begin
            want = pending_hash_results.pop_front();
            if (rsp_chan.hash_value !== want.hash_value) begin
               report_mismatch($sformatf("hash_value got %h want %h",
                                         rsp_chan.hash_value, want.hash_value));
            end
            if (rsp_chan.status !== want.status) begin
               report_mismatch($sformatf("status got %0d want %0d", rsp_chan.status, want.status));
            end
            if (rsp_chan.string_length !== want.string_length) begin
               report_mismatch($sformatf("string_length got %0d want %0d",
                                         rsp_chan.string_length, want.string_length));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  quiet_cycles, pending_hash_results.size());
         $display("** double_prefix_rolling_hash_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_APPEND;
      req_chan.restart     = 1'b0;
      req_chan.symbol      = '0;
      req_chan.first_index = '0;
      req_chan.last_index  = '0;
      model_len            = 0;
      model_pow_first[0]   = 1;
      model_pow_second[0]  = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_store_full();
      test_backpressure();
      test_random();

      req_chan.valid <= 1'b0;
      while (pending_hash_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** double_prefix_rolling_hash_top: PASSED **");
      end else begin
         $display("** double_prefix_rolling_hash_top: FAILED **");
      end
      $finish;
   end

endmodule
